// ----- sv/bfba_pkg.sv -----
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfba_pkg;

  localparam int DISK_BLOCKS_C = 32;

  localparam int SIZE_W      = 16;   // file size in bytes
  localparam int BS_W        = 12;   // block size register
  localparam int BLK_W       = 5;    // block index / first_block / position
  localparam int CNT_W       = 6;    // block_count
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [BS_W-1:0]  BLOCK_SIZE_RST = 12'd50;
  localparam logic [CNT_W-1:0] COUNT_SAT      = 6'd63;

  typedef enum logic [1:0] {
    REQ_CONTIG = 2'd0,
    REQ_SCAT   = 2'd1,
    REQ_MARK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ZERO,
    EMIT_NOROOM,
    EMIT_MARK,
    EMIT_CONTIG,
    EMIT_SCAT
  } emit_t;

  // controller -> datapath
  typedef struct packed {
    logic  load;        // capture request, start divider
    logic  scan_clr;    // reset scan pointer and counters
    logic  scan_step;   // examine one block of the bitmap
    logic  skip;        // advance pointer past a used block
    emit_t emit;        // load a result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t req_type;
    logic div_done;
    logic need_zero;
    logic need_big;
    logic hit;
    logic scan_end;
    logic cur_free;
    logic out_free;
    logic scat_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/bfba_div.sv -----
// ----------------------------------------------------------------------------
// bfba_div
// Restoring divider, one quotient bit per cycle, file size by block size.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_div import bfba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SIZE_W-1:0] dividend,
  input  logic [BS_W-1:0]   divisor,
  output logic [SIZE_W-1:0] quotient,
  output logic              rem_nz,
  output logic              done
);

  localparam int STEP_W = $clog2(SIZE_W + 1);

  logic [SIZE_W-1:0] quo_r;
  logic [BS_W-1:0]   rem_r;
  logic [BS_W-1:0]   dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [BS_W:0] shifted;
  logic [BS_W:0] diff;
  logic          ge;

  assign shifted = {rem_r, quo_r[SIZE_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(SIZE_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SIZE_W-2:0], ge};
      rem_r <= ge ? diff[BS_W-1:0] : shifted[BS_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign rem_nz   = |rem_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// ----- sv/bfba_dp.sv -----
// ----------------------------------------------------------------------------
// bfba_dp
// Datapath: block size register, used bitmap, scan counters, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_dp import bfba_pkg::*; #(
  parameter int DISK_BLOCKS = DISK_BLOCKS_C
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   cfg_wr_en,
  input  logic [BS_W-1:0]        cfg_wr_data,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int IW = $clog2(DISK_BLOCKS);
  localparam int CW = $clog2(DISK_BLOCKS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DISK_BLOCKS - 1);

  logic [BS_W-1:0]        block_size_r;
  req_t                   type_r;
  logic [BLK_W-1:0]       blk_r;
  logic [SIZE_W-1:0]      need_r;
  logic [DISK_BLOCKS-1:0] used_r;
  logic [DISK_BLOCKS-1:0] used_nxt;
  logic [IW-1:0]          idx_r;
  logic [IW-1:0]          start_r;
  logic [CW-1:0]          run_r;
  logic [CW-1:0]          got_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;

  logic [BS_W-1:0]   divisor;
  logic [SIZE_W-1:0] quotient;
  logic              rem_nz;
  logic              div_done;

  logic [CW-1:0]     need_c;
  logic              cur_free;
  logic              out_free;
  logic              mark_bad;
  logic              scat_last;
  logic              hit;

  logic              res_status;
  logic [BLK_W-1:0]  res_first;
  logic [BLK_W-1:0]  res_pos;
  logic [CNT_W-1:0]  res_cnt;
  logic              res_last;

  // zero block size behaves as one byte per block
  assign divisor = (block_size_r == '0) ? BS_W'(1) : block_size_r;

  bfba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .dividend (in_tdata[SIZE_W-1:0]),
    .divisor  (divisor),
    .quotient (quotient),
    .rem_nz   (rem_nz),
    .done     (div_done)
  );

  assign need_c    = need_r[CW-1:0];
  assign cur_free  = !used_r[idx_r];
  assign out_free  = !out_valid_r || out_tready;
  assign mark_bad  = 32'(blk_r) >= 32'(DISK_BLOCKS);
  assign scat_last = (got_r + 1'b1) == need_c;
  assign hit       = cur_free && ((type_r == REQ_CONTIG) ? ((run_r + 1'b1) == need_c)
                                                         : scat_last);

  always_comb begin
    sts           = '0;
    sts.req_type  = type_r;
    sts.div_done  = div_done;
    sts.need_zero = need_r == '0;
    sts.need_big  = need_r > SIZE_W'(DISK_BLOCKS);
    sts.hit       = hit;
    sts.scan_end  = idx_r == LAST_IDX;
    sts.cur_free  = cur_free;
    sts.out_free  = out_free;
    sts.scat_last = scat_last;
  end

  // result fields for the transaction being loaded
  always_comb begin
    res_status = 1'b0;
    res_first  = '0;
    res_pos    = '0;
    res_cnt    = '0;
    res_last   = 1'b1;
    case (cmd.emit)
      EMIT_NOROOM: begin
        res_status = 1'b1;
        res_cnt    = (need_r > SIZE_W'(COUNT_SAT)) ? COUNT_SAT : need_r[CNT_W-1:0];
      end
      EMIT_MARK: begin
        res_status = mark_bad;
        res_first  = blk_r;
        res_cnt    = mark_bad ? CNT_W'(0) : CNT_W'(1);
      end
      EMIT_CONTIG: begin
        res_first = BLK_W'(start_r);
        res_cnt   = need_r[CNT_W-1:0];
      end
      EMIT_SCAT: begin
        res_first = BLK_W'(idx_r);
        res_pos   = BLK_W'(got_r);
        res_cnt   = need_r[CNT_W-1:0];
        res_last  = scat_last;
      end
      default: ;
    endcase
  end

  always_comb begin
    used_nxt = used_r;
    case (cmd.emit)
      EMIT_MARK: begin
        for (int j = 0; j < DISK_BLOCKS; j++) begin
          if (!mark_bad && (32'(j) == 32'(blk_r))) used_nxt[j] = 1'b1;
        end
      end
      EMIT_CONTIG: begin
        // the run ends where the scan pointer stopped
        for (int j = 0; j < DISK_BLOCKS; j++) begin
          if ((32'(j) >= 32'(start_r)) && (32'(j) <= 32'(idx_r))) used_nxt[j] = 1'b1;
        end
      end
      EMIT_SCAT: used_nxt[idx_r] = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RST;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) block_size_r <= cfg_wr_data;
      used_r <= used_nxt;
      if (cmd.emit != EMIT_NONE) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= req_t'(in_tuser);
      blk_r  <= in_tdata[SIZE_W+BLK_W-1:SIZE_W];
    end
    if (div_done) need_r <= quotient + SIZE_W'(rem_nz);
    if (cmd.emit != EMIT_NONE) begin
      out_data_r <= {(OUT_TDATA_W-1-2*BLK_W-CNT_W)'(0), res_cnt, res_pos, res_first,
                     res_status};
      out_last_r <= res_last;
    end
    if (cmd.scan_clr) begin
      idx_r   <= '0;
      start_r <= '0;
      run_r   <= '0;
      got_r   <= '0;
    end else if (cmd.scan_step) begin
      run_r <= cur_free ? run_r + 1'b1 : '0;
      got_r <= got_r + CW'(cur_free);
      if (cur_free && (run_r == '0)) start_r <= idx_r;
      if (!hit) idx_r <= idx_r + 1'b1;
    end else if (cmd.skip) begin
      idx_r <= idx_r + 1'b1;
    end else if (cmd.emit == EMIT_SCAT) begin
      idx_r <= idx_r + 1'b1;
      got_r <= got_r + 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit != EMIT_NONE) |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken transaction");

  a_contig_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit == EMIT_CONTIG) |=> used_r[start_r])
    else $error("contiguous run start not marked used");

  a_scat_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit == EMIT_SCAT) |=> used_r[$past(idx_r)])
    else $error("scattered block not marked used");

endmodule

`default_nettype wire

// ----- sv/bfba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfba_ctrl
// Request sequencer: decode, divide, bitmap scan and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_ctrl import bfba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MARK,
    S_DIV,
    S_CHECK,
    S_ZERO,
    S_NOROOM,
    S_SCAN,
    S_CONTIG,
    S_SEMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = EMIT_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req_type)
          REQ_MARK: state_nxt = S_MARK;
          REQ_NONE: state_nxt = S_IDLE;
          default:  state_nxt = S_DIV;
        endcase
      end
      S_MARK: begin
        if (sts.out_free) begin
          cmd.emit  = EMIT_MARK;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.need_zero) begin
          state_nxt = S_ZERO;
        end else if (sts.need_big) begin
          state_nxt = S_NOROOM;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_ZERO: begin
        if (sts.out_free) begin
          cmd.emit  = EMIT_ZERO;
          state_nxt = S_IDLE;
        end
      end
      S_NOROOM: begin
        if (sts.out_free) begin
          cmd.emit  = EMIT_NOROOM;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.hit && (sts.req_type == REQ_CONTIG)) begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_CONTIG;
        end else if (sts.hit) begin
          // enough free blocks seen, rewind and hand them out
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SEMIT;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_end) state_nxt = S_NOROOM;
        end
      end
      S_CONTIG: begin
        if (sts.out_free) begin
          cmd.emit  = EMIT_CONTIG;
          state_nxt = S_IDLE;
        end
      end
      S_SEMIT: begin
        if (!sts.cur_free) begin
          cmd.skip = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit = EMIT_SCAT;
          if (sts.scat_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (!sts.need_zero && !sts.need_big))
    else $error("bitmap scan with a block count outside the disk");

  a_semit_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEMIT && !sts.cur_free) |=> (state_r == S_SEMIT))
    else $error("scattered emission left on a used block");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> ($past(state_r) == S_DIV))
    else $error("size check entered without a finished division");

endmodule

`default_nettype wire

// ----- sv/bitmap_file_block_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_file_block_allocator
// Used/free bitmap of disk blocks with contiguous and scattered allocation.
// ----------------------------------------------------------------------------
// One request is handled at a time. A mark request goes from acceptance
// through the decode and mark states to its result. An allocate request
// first divides the file size by the block size in a bit-serial divider,
// after which the block count is known; zero-size and too-large requests
// then go straight to their result. The bitmap is then scanned one block per
// cycle to find the run or the free blocks. A scattered allocation then
// walks the bitmap again at one block per cycle, holding on a free block
// while the output register is occupied, and emits one transaction per
// allocated block. The last result sits in the output register while the
// next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_file_block_allocator import bfba_pkg::*; #(
  parameter int DISK_BLOCKS = DISK_BLOCKS_C
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] file_size, [20:16] block_index, [23:21] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] status, [5:1] first_block, [10:6] position, [16:11] block_count,
  // [23:17] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_wr_en,
  input  logic [BS_W-1:0]        cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  bfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfba_dp #(
    .DISK_BLOCKS (DISK_BLOCKS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire

// ----- dv/bitmap_file_block_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_file_block_allocator_tb
// Streams allocate and mark requests into the allocator and checks every
// result against a cycle-free prediction of the block bitmap. Runs a directed
// set at the reset block size, then random traffic under several block sizes,
// some of it with backpressure and source gaps on both sides.
// ----------------------------------------------------------------------------

module bitmap_file_block_allocator_tb;
  import bfba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          SETTLE_CYC  = 150;

  typedef struct {
    req_t        kind;
    logic [15:0] size;
    logic [4:0]  idx;
  } alloc_req_t;

  typedef struct packed {
    logic             status;
    logic [BLK_W-1:0] first_block;
    logic [BLK_W-1:0] position;
    logic [CNT_W-1:0] block_count;
    logic             last;
  } alloc_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [BS_W-1:0]        cfg_wr_data = '0;

  alloc_req_t             alloc_req_q[$];
  alloc_result_t          expected_result_q[$];
  logic [DISK_BLOCKS_C-1:0] disk_used_map = '0;
  logic [BS_W-1:0]        block_size_cfg = BLOCK_SIZE_RST;
  logic                   in_taken = 1'b0;
  int unsigned            sender_idle_pct = 0;
  int unsigned            recv_idle_pct = 0;
  int unsigned            mismatch_count = 0;
  int unsigned            cycle_count = 0;

  bitmap_file_block_allocator uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // expected results of one request, updating the shadow bitmap
  task automatic predict_allocation(req_t kind, logic [15:0] size, logic [4:0] idx);
    alloc_result_t            res;
    int unsigned              bs;
    int unsigned              need;
    int unsigned              run;
    int unsigned              start;
    int unsigned              got;
    logic [DISK_BLOCKS_C-1:0] pick;
    bs = (block_size_cfg == '0) ? 1 : block_size_cfg;
    need = size / bs + (((size % bs) != 0) ? 1 : 0);
    res = '0;
    res.last = 1'b1;
    if (kind == REQ_NONE) return;
    if (kind == REQ_MARK) begin
      res.first_block = idx;
      if (idx >= DISK_BLOCKS_C) begin
        res.status = 1'b1;
      end else begin
        disk_used_map[idx] = 1'b1;
        res.block_count = CNT_W'(1);
      end
      expected_result_q.push_back(res);
      return;
    end
    res.block_count = (need > COUNT_SAT) ? COUNT_SAT : CNT_W'(need);
    if (need == 0) begin
      expected_result_q.push_back(res);
      return;
    end
    if (need > DISK_BLOCKS_C) begin
      res.status = 1'b1;
      expected_result_q.push_back(res);
      return;
    end
    if (kind == REQ_CONTIG) begin
      run = 0;
      start = 0;
      for (int i = 0; i < DISK_BLOCKS_C; i++) begin
        if (disk_used_map[i]) begin
          run = 0;
        end else begin
          if (run == 0) start = i;
          run++;
          if (run == need) break;
        end
      end
      if (run != need) begin
        res.status = 1'b1;
      end else begin
        for (int unsigned i = start; i < start + need; i++) disk_used_map[i] = 1'b1;
        res.first_block = BLK_W'(start);
      end
      expected_result_q.push_back(res);
      return;
    end
    // scattered: lowest free blocks, one transaction per block
    got = 0;
    pick = '0;
    for (int i = 0; i < DISK_BLOCKS_C && got < need; i++) begin
      if (!disk_used_map[i]) begin
        pick[i] = 1'b1;
        got++;
      end
    end
    if (got != need) begin
      res.status = 1'b1;
      expected_result_q.push_back(res);
      return;
    end
    got = 0;
    for (int i = 0; i < DISK_BLOCKS_C; i++) begin
      if (pick[i]) begin
        res.first_block = BLK_W'(i);
        res.position = BLK_W'(got);
        res.last = (got + 1 == need);
        expected_result_q.push_back(res);
        got++;
      end
    end
    disk_used_map |= pick;
  endtask

  // input side: predict on acceptance; output side: compare with oldest
  always @(posedge clk) begin : monitor
    alloc_result_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      predict_allocation(req_t'(in_tuser), in_tdata[15:0], in_tdata[20:16]);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_result_q.size() == 0) begin
        report_mismatch("unexpected result, tdata", out_tdata, 0);
      end else begin
        want = expected_result_q.pop_front();
        if (out_tdata[0] !== want.status)
          report_mismatch("status", out_tdata[0], want.status);
        if (out_tdata[5:1] !== want.first_block)
          report_mismatch("first_block", out_tdata[5:1], want.first_block);
        if (out_tdata[10:6] !== want.position)
          report_mismatch("position", out_tdata[10:6], want.position);
        if (out_tdata[16:11] !== want.block_count)
          report_mismatch("block_count", out_tdata[16:11], want.block_count);
        if (out_tlast !== want.last)
          report_mismatch("last", out_tlast, want.last);
      end
    end
  end

  always @(negedge clk) begin : driver
    alloc_req_t cur;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (alloc_req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        cur = alloc_req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {3'b000, cur.idx, cur.size};
        in_tuser  <= cur.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_file_block_allocator: mismatch");
      $finish;
    end
  end

  task automatic push_req(req_t kind, int unsigned size, int unsigned idx);
    alloc_req_t r;
    r.kind = kind;
    r.size = size;
    r.idx  = idx;
    alloc_req_q.push_back(r);
  endtask

  task automatic queue_random_requests(int count);
    alloc_req_t  r;
    int unsigned bs;
    int unsigned need;
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    bs = (block_size_cfg == '0) ? 1 : block_size_cfg;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 40)      r.kind = REQ_CONTIG;
      else if (roll < 78) r.kind = REQ_SCAT;
      else if (roll < 94) r.kind = REQ_MARK;
      else                r.kind = REQ_NONE;
      r.idx  = $urandom_range(31);
      r.size = $urandom;
      // mostly small block counts so the bitmap fills gradually
      roll = $urandom_range(99);
      if (roll < 65)      need = $urandom_range(2, 1);
      else if (roll < 85) need = $urandom_range(8, 3);
      else if (roll < 93) need = 0;
      else                need = 1000;
      if (need == 0) begin
        r.size = 0;
      end else if (need != 1000) begin
        lo = (need - 1) * bs + 1;
        hi = need * bs;
        if (hi > 65535) hi = 65535;
        if (lo <= hi) r.size = $urandom_range(hi, lo);
      end
      alloc_req_q.push_back(r);
    end
  endtask

  task automatic wait_drained();
    while (alloc_req_q.size() != 0 || in_tvalid || expected_result_q.size() != 0)
      @(negedge clk);
    // a type-3 request leaves nothing to wait for, so give it time to clear
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_block_size(logic [BS_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en      <= 1'b0;
    block_size_cfg = value;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 25;
    recv_idle_pct   = 67;

    // directed set at the reset block size
    push_req(REQ_CONTIG, 0, 0);
    push_req(REQ_CONTIG, 1, 31);
    push_req(REQ_CONTIG, 50, 0);
    push_req(REQ_CONTIG, 51, 0);
    push_req(REQ_SCAT, 100, 0);
    push_req(REQ_MARK, 0, 10);
    push_req(REQ_MARK, 0, 10);
    push_req(REQ_MARK, 16'hFFFF, 31);
    push_req(REQ_CONTIG, 250, 0);
    push_req(REQ_SCAT, 150, 0);
    push_req(REQ_CONTIG, 16'hFFFF, 0);
    push_req(REQ_SCAT, 16'hFFFF, 31);
    push_req(REQ_CONTIG, 1600, 0);
    push_req(REQ_SCAT, 1601, 0);
    push_req(REQ_NONE, 16'hFFFF, 31);
    push_req(REQ_MARK, 0, 0);
    push_req(REQ_SCAT, 0, 5);
    push_req(REQ_SCAT, 49, 0);
    push_req(REQ_CONTIG, 1, 0);
    push_req(REQ_CONTIG, 750, 0);
    wait_drained();

    write_block_size(12'd4095);
    queue_random_requests(45);
    wait_drained();

    sender_idle_pct = 67;
    recv_idle_pct   = 25;
    write_block_size(12'd1);
    queue_random_requests(45);
    wait_drained();

    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    // zero block size behaves as one byte per block
    write_block_size(12'd0);
    queue_random_requests(25);
    wait_drained();

    write_block_size($urandom_range(4095, 1));
    queue_random_requests(25);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("bitmap_file_block_allocator: match");
    end else begin
      $display("bitmap_file_block_allocator: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bfba_pkg.sv
sv/bfba_div.sv
sv/bfba_dp.sv
sv/bfba_ctrl.sv
sv/bitmap_file_block_allocator.sv
dv/bitmap_file_block_allocator_tb.sv
